// File: rtl/core/scp_pkg.sv
// scp_pkg: shared types, constants and pulse arithmetic for the servo command parser
// no dependencies; imported by the parser, the top level and the checker
`default_nettype none

package scp_pkg;

  // frame characters
  localparam logic [7:0] StartChar = 8'h25;  // '%'
  localparam logic [7:0] SepChar   = 8'h24;  // '$'
  localparam logic [7:0] DigitZero = 8'h30;  // '0'
  localparam logic [7:0] DigitNine = 8'h39;  // '9'

  // frame geometry
  localparam int unsigned FrameLen = 9;
  localparam int unsigned PosW     = 4;
  localparam logic [PosW-1:0] PosLastX = PosW'(3);
  localparam logic [PosW-1:0] PosSep   = PosW'(4);
  localparam logic [PosW-1:0] PosLast  = PosW'(FrameLen - 1);

  // field and register widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DegW   = 8;
  localparam int unsigned PulseW = 16;
  localparam int unsigned StepW  = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // register defaults
  localparam logic [PulseW-1:0] PulseBaseDefault = PulseW'(625);
  localparam logic [StepW-1:0]  PulseStepDefault = StepW'(3);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PULSE_BASE    = 1'b0,
    CFG_PULSE_PER_DEG = 1'b1
  } cfg_reg_e;

  // parse outcome of one accepted byte
  typedef struct packed {
    logic            done;
    logic [DegW-1:0] x_deg;
    logic [DegW-1:0] y_deg;
  } frame_t;

  // base + deg * step, clipped to full scale
  function automatic logic [PulseW-1:0] pulse_of(logic [PulseW-1:0] base,
                                                 logic [StepW-1:0]  step,
                                                 logic [DegW-1:0]   deg);
    logic [PulseW-1:0] prod;
    logic [PulseW:0]   sum;
    prod = PulseW'({8'd0, deg} * {8'd0, step});
    sum  = {1'b0, base} + {1'b0, prod};
    pulse_of = sum[PulseW] ? {PulseW{1'b1}} : sum[PulseW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/scp_frame_parser.sv
// scp_frame_parser: byte position tracking and decimal angle accumulation
// depends on scp_pkg
`default_nettype none

module scp_frame_parser
  import scp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [ByteW-1:0] rx_byte_i,
  output frame_t                frame_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [DegW-1:0] x_acc_q, x_acc_d, y_acc_q, y_acc_d;
  logic            x_run_q, x_run_d, y_run_q, y_run_d;
  logic            sep_ok_q, sep_ok_d;

  logic            hunting;
  logic            is_digit;
  logic [DegW-1:0] digit_val;
  logic            done;

  assign hunting   = (pos_q == '0) || (pos_q > PosLast);
  assign is_digit  = (rx_byte_i >= DigitZero) && (rx_byte_i <= DigitNine);
  assign digit_val = rx_byte_i - DigitZero;

  always_comb begin
    pos_d    = pos_q;
    x_acc_d  = x_acc_q;
    y_acc_d  = y_acc_q;
    x_run_d  = x_run_q;
    y_run_d  = y_run_q;
    sep_ok_d = sep_ok_q;
    done     = 1'b0;
    if (hunting) begin
      pos_d = '0;
      if (rx_byte_i == StartChar) begin
        pos_d    = PosW'(1);
        x_acc_d  = '0;
        y_acc_d  = '0;
        x_run_d  = 1'b1;
        y_run_d  = 1'b1;
        sep_ok_d = 1'b0;
      end
    end else begin
      if (pos_q <= PosLastX) begin
        if (x_run_q && is_digit) begin
          // acc * 10 as two shifts, kept modulo 256
          x_acc_d = (x_acc_q << 3) + (x_acc_q << 1) + digit_val;
        end else begin
          x_run_d = 1'b0;
        end
      end else if (pos_q == PosSep) begin
        sep_ok_d = (rx_byte_i == SepChar);
      end else begin
        if (y_run_q && is_digit) begin
          y_acc_d = (y_acc_q << 3) + (y_acc_q << 1) + digit_val;
        end else begin
          y_run_d = 1'b0;
        end
      end
      if (pos_q == PosLast) begin
        pos_d = '0;
        done  = sep_ok_q;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  assign frame_o.done  = done;
  assign frame_o.x_deg = x_acc_d;
  assign frame_o.y_deg = y_acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      x_acc_q  <= '0;
      y_acc_q  <= '0;
      x_run_q  <= 1'b0;
      y_run_q  <= 1'b0;
      sep_ok_q <= 1'b0;
    end else if (accept_i) begin
      pos_q    <= pos_d;
      x_acc_q  <= x_acc_d;
      y_acc_q  <= y_acc_d;
      x_run_q  <= x_run_d;
      y_run_q  <= y_run_d;
      sep_ok_q <= sep_ok_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/servo_command_frame_parser_core.sv
// Servo command frame parser. Takes one received byte per transfer on the
// input channel and hunts for 9-byte frames "%ddd$dddd". The X angle is the
// value of the leading decimal digits in bytes 1 to 3, the Y angle that of
// bytes 5 to 8 (stopping at '#' or any non-digit); both are kept modulo 256.
// A frame whose byte 4 is not '$' is consumed and dropped. Each good frame
// yields one output transfer with both angles and the compare values
// pulse_base + angle * pulse_per_degree, clipped at 65535. Rate: one byte per
// clock while in_ready_o is high; the parser state updates in the cycle a byte is
// taken, the frame result is captured in a degree register with the last byte of
// its frame and is turned into pulses on the way into the output register.
// in_ready_o falls only while both the degree register and the output register
// hold results that the consumer has not taken.
// Configuration writes take effect at once and belong in idle periods.
// file depends on scp_pkg and scp_frame_parser
`default_nettype none

module servo_command_frame_parser_core
  import scp_pkg::*;
#(
  parameter logic [PulseW-1:0] PulseBaseReset = PulseBaseDefault,
  parameter logic [StepW-1:0]  PulseStepReset = PulseStepDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  // received bytes
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire logic [ByteW-1:0]    rx_byte_i,
  // frame results
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic [PulseW-1:0]   x_pulse_o,
  output      logic [PulseW-1:0]   y_pulse_o,
  output      logic [DegW-1:0]     x_degrees_o,
  output      logic [DegW-1:0]     y_degrees_o
);

  // configuration registers
  logic [PulseW-1:0] pulse_base_q;
  logic [StepW-1:0]  pulse_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_base_q <= PulseBaseReset;
      pulse_step_q <= PulseStepReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_PULSE_BASE:    pulse_base_q <= cfg_wdata_i[PulseW-1:0];
        CFG_PULSE_PER_DEG: pulse_step_q <= cfg_wdata_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the degree stage moves on when the output register is free
  // or being emptied in this cycle
  logic   in_xfer;
  logic   out_free;
  logic   deg_free;
  frame_t frame;

  logic            deg_valid_q;
  logic [DegW-1:0] deg_x_q, deg_y_q;
  logic            out_valid_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign deg_free   = !deg_valid_q || out_free;
  assign in_ready_o = deg_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  scp_frame_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_xfer),
    .rx_byte_i (rx_byte_i),
    .frame_o   (frame)
  );

  // degree stage: holds the angles of a completed good frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_valid_q <= 1'b0;
    end else if (deg_free) begin
      deg_valid_q <= in_xfer && frame.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (deg_free && in_xfer && frame.done) begin
      deg_x_q <= frame.x_deg;
      deg_y_q <= frame.y_deg;
    end
  end

  // output stage: pulse arithmetic on the way in, one multiplier per axis
  logic [PulseW-1:0] x_pulse_q, y_pulse_q;
  logic [DegW-1:0]   x_deg_q, y_deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= deg_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && deg_valid_q) begin
      x_pulse_q <= pulse_of(pulse_base_q, pulse_step_q, deg_x_q);
      y_pulse_q <= pulse_of(pulse_base_q, pulse_step_q, deg_y_q);
      x_deg_q   <= deg_x_q;
      y_deg_q   <= deg_y_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign x_pulse_o   = x_pulse_q;
  assign y_pulse_o   = y_pulse_q;
  assign x_degrees_o = x_deg_q;
  assign y_degrees_o = y_deg_q;

endmodule

`default_nettype wire

// File: rtl/core/scp_checker.sv
// scp_checker: port-level assertions for servo_command_frame_parser_core
// depends on scp_pkg; attached to the top level by the bind at the end
`default_nettype none

module scp_checker
  import scp_pkg::*;
#(
  parameter logic [PulseW-1:0] PulseBaseReset = PulseBaseDefault
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                cfg_we_i,
  input wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input wire logic [CfgDataW-1:0] cfg_wdata_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire logic [PulseW-1:0]   x_pulse_o,
  input wire logic [PulseW-1:0]   y_pulse_o,
  input wire logic [DegW-1:0]     x_degrees_o,
  input wire logic [DegW-1:0]     y_degrees_o
);

  // shadow of the base register as seen on the write port
  logic [PulseW-1:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= PulseBaseReset;
    end else if (cfg_we_i && (cfg_idx_i == CFG_PULSE_BASE)) begin
      base_q <= cfg_wdata_i[PulseW-1:0];
    end
  end

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(x_pulse_o) && $stable(y_pulse_o)
      && $stable(x_degrees_o) && $stable(y_degrees_o))
    else $error("result payload changed while stalled");

  // input only backs up when a result is waiting at the output
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // pulse arithmetic never wraps below the base
  a_pulse_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (x_pulse_o >= base_q) && (y_pulse_o >= base_q))
    else $error("pulse below base value");

  // an X angle of zero gives exactly the base value
  a_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (x_degrees_o == '0) |-> x_pulse_o == base_q)
    else $error("zero angle pulse differs from base");

endmodule

bind servo_command_frame_parser_core scp_checker #(
  .PulseBaseReset (PulseBaseReset)
) u_scp_checker (.*);

`default_nettype wire

// File: test/tb_servo_command_frame_parser_core.sv
// testbench for servo_command_frame_parser_core: directed frame table, then random frames
// under several pulse settings, results checked against fixed rows or an in-bench parser
// depends on scp_pkg and the servo_command_frame_parser_core rtl
`timescale 1ns / 1ps

module tb_servo_command_frame_parser_core;
  import scp_pkg::*;

  localparam int unsigned Limit       = 200000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned PhaseItems  = 100;
  localparam int unsigned NumPhases   = 7;
  localparam logic [7:0]  HashChar    = 8'h23;  // '#'

  // one frame result as it leaves the block
  typedef struct packed {
    logic [PulseW-1:0] x_pulse;
    logic [PulseW-1:0] y_pulse;
    logic [DegW-1:0]   x_deg;
    logic [DegW-1:0]   y_deg;
  } frame_res_t;

  // one row of the directed byte table; fixed rows carry their own expectation
  typedef struct {
    logic [ByteW-1:0] rx;
    bit               fixed;
    bit               has_res;
    frame_res_t       res;
  } stim_row_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = CFG_PULSE_BASE;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [ByteW-1:0]    rx_byte   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [PulseW-1:0]   x_pulse;
  logic [PulseW-1:0]   y_pulse;
  logic [DegW-1:0]     x_deg;
  logic [DegW-1:0]     y_deg;

  servo_command_frame_parser_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .x_pulse_o   (x_pulse),
    .y_pulse_o   (y_pulse),
    .x_degrees_o (x_deg),
    .y_degrees_o (y_deg)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // parser mirror: register copies and frame state
  logic [PulseW-1:0] base_cfg = PulseBaseDefault;
  logic [StepW-1:0]  step_cfg = PulseStepDefault;
  logic [PosW-1:0]   frame_pos = '0;
  logic [DegW-1:0]   x_angle = '0;
  logic [DegW-1:0]   y_angle = '0;
  logic              x_run = 1'b0;
  logic              y_run = 1'b0;
  logic              sep_seen = 1'b0;

  frame_res_t  pending_frames[$];  // results still owed by the block
  stim_row_t   frame_table[$];
  bit          no_idle = 1'b0;     // both sides run without gaps while set
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  function automatic bit is_digit(logic [ByteW-1:0] c);
    return c >= DigitZero && c <= DigitNine;
  endfunction

  // base + deg * step, clipped to full scale
  function automatic logic [PulseW-1:0] clip_pulse(logic [DegW-1:0] deg);
    int unsigned sum;
    sum = 32'(base_cfg) + 32'(deg) * 32'(step_cfg);
    return (sum > 32'hFFFF) ? 16'hFFFF : 16'(sum);
  endfunction

  // advances the mirror by one byte; returns 1 when a good frame completes
  function automatic bit parse_byte(logic [ByteW-1:0] c, output frame_res_t r);
    logic [PosW-1:0] pos;
    pos = frame_pos;
    r = '0;
    // hunting, or a position past the frame end
    if (pos == 0 || pos >= FrameLen) begin
      frame_pos = '0;
      if (c == StartChar) begin
        frame_pos = PosW'(1);
        x_angle   = '0;
        x_run     = 1'b1;
        y_angle   = '0;
        y_run     = 1'b1;
        sep_seen  = 1'b0;
      end
      return 1'b0;
    end
    if (pos <= PosLastX) begin
      if (x_run && is_digit(c)) x_angle = x_angle * 8'd10 + (c - DigitZero);
      else x_run = 1'b0;
    end else if (pos == PosSep) begin
      sep_seen = (c == SepChar);
    end else begin
      if (y_run && is_digit(c)) y_angle = y_angle * 8'd10 + (c - DigitZero);
      else y_run = 1'b0;
    end
    if (pos != PosLast) begin
      frame_pos = pos + PosW'(1);
      return 1'b0;
    end
    // last byte: emit only when the separator was right
    frame_pos = '0;
    if (!sep_seen) return 1'b0;
    r.x_pulse = clip_pulse(x_angle);
    r.y_pulse = clip_pulse(y_angle);
    r.x_deg   = x_angle;
    r.y_deg   = y_angle;
    return 1'b1;
  endfunction

  task automatic add_text(string s);
    foreach (s[i]) frame_table.push_back('{rx: s[i], fixed: 1'b0, has_res: 1'b0, res: '0});
  endtask

  task automatic add_fixed(logic [ByteW-1:0] b, bit has_res, frame_res_t res);
    frame_table.push_back('{rx: b, fixed: 1'b1, has_res: has_res, res: res});
  endtask

  // one input transfer; the mirror steps at the accepting edge
  task automatic send_byte(logic [ByteW-1:0] b, bit fixed, bit has_res, frame_res_t res);
    int unsigned gap;
    frame_res_t  pred;
    bit          got;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (!in_ready);
    got = parse_byte(b, pred);
    if (fixed) begin
      if (has_res) pending_frames.push_back(res);
    end else if (got) begin
      pending_frames.push_back(pred);
    end
  endtask

  // frame content: mostly digits, some terminators and stray bytes
  function automatic logic [ByteW-1:0] frame_char();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r <= 7) return DigitZero + 8'($urandom_range(0, 9));
    if (r <= 9) return DigitNine;
    if (r == 10) return HashChar;
    if (r == 11) return StartChar;
    if (r == 12) return SepChar;
    return 8'($urandom_range(0, 255));
  endfunction

  // well-formed frame with random content; now and then a bad separator
  task automatic send_frame();
    send_byte(StartChar, 1'b0, 1'b0, '0);
    repeat (3) send_byte(frame_char(), 1'b0, 1'b0, '0);
    if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
    else send_byte(SepChar, 1'b0, 1'b0, '0);
    repeat (4) send_byte(frame_char(), 1'b0, 1'b0, '0);
  endtask

  // drop valid and let the block drain before a register write
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_PULSE_BASE:    base_cfg = val;
      CFG_PULSE_PER_DEG: step_cfg = val[StepW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // cycle budget for the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= Limit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stall per result, compare on each output transfer
  initial begin
    int unsigned stall;
    frame_res_t  seen;
    frame_res_t  want;
    wait (rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      seen = {x_pulse, y_pulse, x_deg, y_deg};
      if (pending_frames.size() == 0) begin
        err_count++;
        if (err_count <= MaxReports)
          $display("unexpected result: x_pulse=%0d y_pulse=%0d x_deg=%0d y_deg=%0d",
                   seen.x_pulse, seen.y_pulse, seen.x_deg, seen.y_deg);
      end else begin
        want = pending_frames.pop_front();
        if (seen !== want) begin
          err_count++;
          if (err_count <= MaxReports)
            $display("mismatch: exp x_pulse=%0d y_pulse=%0d x_deg=%0d y_deg=%0d, got %0d %0d %0d %0d",
                     want.x_pulse, want.y_pulse, want.x_deg, want.y_deg,
                     seen.x_pulse, seen.y_pulse, seen.x_deg, seen.y_deg);
        end
      end
    end
  end

  // stimulus: reset, directed table at reset settings, then random phases
  initial begin
    logic [PulseW-1:0] base_v;
    logic [StepW-1:0]  step_v;
    int unsigned       count;
    int unsigned       len;
    int unsigned       kind;

    // noise while hunting is ignored
    add_fixed(8'h00, 1'b0, '0);
    // all-zero frame right after reset gives the reset base on both servos
    add_text("%000$000");
    add_fixed(DigitZero, 1'b1, {16'd625, 16'd625, 8'd0, 8'd0});
    // start byte inside a frame, no digits on either side, y stopped by hash
    add_text("%%a#$#%9");
    add_fixed("Z", 1'b1, {16'd625, 16'd625, 8'd0, 8'd0});
    // bad separator, all-ones byte in its place: frame dropped
    add_text("%999");
    add_fixed(8'hFF, 1'b0, '0);
    add_text("999");
    add_fixed(DigitNine, 1'b0, '0);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (frame_table[i])
      send_byte(frame_table[i].rx, frame_table[i].fixed, frame_table[i].has_res,
                frame_table[i].res);

    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin base_v = 16'd0;     step_v = 8'd0;   end
        1: begin base_v = 16'hFFFF;  step_v = 8'hFF;  end
        2: begin base_v = 16'd0;     step_v = 8'hFF;  end
        3: begin base_v = 16'hFFFF;  step_v = 8'd0;   end
        4: begin base_v = 16'($urandom_range(0, 65535)); step_v = 8'($urandom_range(0, 255)); end
        5: begin base_v = 16'($urandom_range(0, 2000));  step_v = 8'($urandom_range(0, 255)); end
        default: begin
          base_v = 16'($urandom_range(60000, 65535));
          step_v = 8'($urandom_range(0, 20));
        end
      endcase
      settle();
      // upper data bits are don't-care for the step register
      write_reg(CFG_PULSE_PER_DEG, {8'($urandom_range(0, 255)), step_v});
      write_reg(CFG_PULSE_BASE, base_v);
      no_idle = ($urandom_range(0, 2) == 0);

      count = 0;
      while (count < PhaseItems) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          // stray byte, ignored unless it happens to be a start byte
          send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        end else if (kind == 1) begin
          // possibly truncated frame, the next bytes run into it
          len = $urandom_range(1, 8);
          send_byte(StartChar, 1'b0, 1'b0, '0);
          repeat (len) send_byte(frame_char(), 1'b0, 1'b0, '0);
          count += len + 1;
        end else begin
          send_frame();
          count += FrameLen;
        end
      end
    end

    settle();
    no_idle = 1'b0;
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
